### rtl/gdd_pkg.sv
// Shared types, constants and calendar tables for the Gregorian day difference block.
`timescale 1ns / 1ps

package gdd_pkg;

    // Field widths
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 17;
    localparam int STAT_W  = 2;
    localparam int YOFF_W  = 8;

    // Valid year window
    localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd1900;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2100;
    localparam logic [YEAR_W-1:0] YEAR_C19 = 12'd1900;
    localparam logic [YEAR_W-1:0] YEAR_C21 = 12'd2100;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_ORDER   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } t_req;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic [STAT_W-1:0]  status;
    } t_rsp;

    // Per-date result from the day number unit
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] day_num;
    } t_date;

    // Length of a month; zero for codes that are not a month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of a month (non-leap)
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

### rtl/gdd_day_num.sv
// Date check and day number (days counted from 1900-01-01) for one date.
`timescale 1ns / 1ps

module gdd_day_num (
    input  logic [gdd_pkg::YEAR_W-1:0]  i_year,
    input  logic [gdd_pkg::MONTH_W-1:0] i_month,
    input  logic [gdd_pkg::DAY_W-1:0]   i_day,
    output gdd_pkg::t_date              o_date
);

    logic [gdd_pkg::YEAR_W-1:0]  year_off;
    logic [gdd_pkg::YOFF_W-1:0]  yo;
    logic [gdd_pkg::YOFF_W:0]    yo_rnd;
    logic [gdd_pkg::YOFF_W-2:0]  leaps;
    logic                        leap;
    logic                        year_ok;
    logic                        month_ok;
    logic                        day_ok;
    logic [gdd_pkg::COUNT_W-1:0] year_days;

    // Offset the year into the valid window; out-of-window years are flagged below
    assign year_off = i_year - gdd_pkg::YEAR_MIN;
    assign yo       = year_off[gdd_pkg::YOFF_W-1:0];

    // Leap year inside the window: multiple of four, not one of the two plain centuries
    assign leap = (yo[1:0] == 2'd0) && (i_year != gdd_pkg::YEAR_C19)
                  && (i_year != gdd_pkg::YEAR_C21);

    // Leap days in the years before this one, counting from 1900 (itself not leap)
    assign yo_rnd = {1'b0, yo} + 9'd3;
    assign leaps  = yo_rnd[gdd_pkg::YOFF_W:2] - {6'd0, (yo != 8'd0)};

    assign year_days = {9'd0, yo} * 17'd365;

    // Validate year, month and day
    assign year_ok  = (i_year >= gdd_pkg::YEAR_MIN) && (i_year <= gdd_pkg::YEAR_MAX);
    assign month_ok = (i_month >= gdd_pkg::MONTH_JAN) && (i_month <= gdd_pkg::MONTH_DEC);
    assign day_ok   = (i_day != 5'd0) && (i_day <= gdd_pkg::month_len(i_month, leap));

    assign o_date.ok      = year_ok && month_ok && day_ok;
    assign o_date.day_num = year_days
                          + {10'd0, leaps}
                          + {8'd0, gdd_pkg::days_before(i_month)}
                          + {16'd0, (leap && (i_month > gdd_pkg::MONTH_FEB))}
                          + {12'd0, i_day};

endmodule

### rtl/gregorian_date_difference.sv
// Top level: registered single-pass Gregorian day difference between two dates.
`timescale 1ns / 1ps
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+--------------------------------------
//  request  | start, busy, i_req         | taken at an edge with start=1, busy=0
//  result   | o_done, o_rsp              | o_done high for one cycle, no stall
//
// One request per cycle; the result passes through the input register, then the
// day-number compare into the result register, which drives o_done and o_rsp.
// busy stays low: every stage advances each cycle and the receiver cannot stall.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.

module gregorian_date_difference (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  gdd_pkg::t_req   i_req,
    output logic            o_done,
    output gdd_pkg::t_rsp   o_rsp
);

    logic          r_req_vld;
    gdd_pkg::t_req r_req;
    logic          r_done;
    gdd_pkg::t_rsp r_rsp;
    gdd_pkg::t_rsp n_rsp;
    gdd_pkg::t_date date_a;
    gdd_pkg::t_date date_b;

    assign busy = 1'b0;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
        r_req <= i_req;
    end

    // Day numbers of both dates
    gdd_day_num u_start_date (
        .i_year  (r_req.start_year),
        .i_month (r_req.start_month),
        .i_day   (r_req.start_day),
        .o_date  (date_a)
    );

    gdd_day_num u_end_date (
        .i_year  (r_req.end_year),
        .i_month (r_req.end_month),
        .i_day   (r_req.end_day),
        .o_date  (date_b)
    );

    // Pick status and count
    always_comb begin
        n_rsp = '0;
        if (!date_a.ok || !date_b.ok) begin
            n_rsp.status = gdd_pkg::ST_INVALID;
        end else if (date_a.day_num > date_b.day_num) begin
            n_rsp.status = gdd_pkg::ST_ORDER;
        end else begin
            n_rsp.status    = gdd_pkg::ST_OK;
            n_rsp.day_count = date_b.day_num - date_a.day_num;
        end
    end

    // Hold the result for one strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_vld;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

### verif/tb_gregorian_date_difference.sv
// Self-checking testbench for the Gregorian day difference block.
`timescale 1ns / 1ps

module tb_gregorian_date_difference;

    // One queued request with the idle rate before it and an optional drain
    typedef struct {
        gdd_pkg::t_req req;
        int            gap_pct;
        bit            drain;
    } t_date_pair;

    // Expected result together with the request that caused it
    typedef struct {
        gdd_pkg::t_req req;
        gdd_pkg::t_rsp rsp;
    } t_expected_diff;

    localparam int PHASE_ITEMS = 225;
    localparam int MAX_REPORTS = 10;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    gdd_pkg::t_req  i_req   = '0;
    logic           busy;
    logic           o_done;
    gdd_pkg::t_rsp  o_rsp;

    t_date_pair      pending_pairs[$];
    t_expected_diff  expected_diffs[$];
    t_expected_diff  oldest_diff;
    t_date_pair      next_pair;
    logic            req_taken = 1'b0;
    logic            drive_start;
    int              error_count = 0;

    gregorian_date_difference u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    function automatic bit is_leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(int y, int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_in_range(int y, int m, int d);
        if (y < int'(gdd_pkg::YEAR_MIN) || y > int'(gdd_pkg::YEAR_MAX)) return 1'b0;
        if (m < 1 || m > 12) return 1'b0;
        return (d >= 1) && (d <= days_in_month(y, m));
    endfunction

    // Days since a fixed epoch; only differences are used
    function automatic int day_serial(int y, int m, int d);
        int n;
        n = 365 * (y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
        for (int k = 1; k < m; k++) n += days_in_month(y, k);
        return n + d;
    endfunction

    function automatic gdd_pkg::t_rsp predict_difference(gdd_pkg::t_req r);
        gdd_pkg::t_rsp rsp;
        int            from_day;
        int            to_day;
        rsp = '0;
        if (!date_in_range(r.start_year, r.start_month, r.start_day) ||
            !date_in_range(r.end_year, r.end_month, r.end_day)) begin
            rsp.status = gdd_pkg::ST_INVALID;
        end else begin
            from_day = day_serial(r.start_year, r.start_month, r.start_day);
            to_day   = day_serial(r.end_year, r.end_month, r.end_day);
            if (from_day > to_day) begin
                rsp.status = gdd_pkg::ST_ORDER;
            end else begin
                rsp.status    = gdd_pkg::ST_OK;
                rsp.day_count = gdd_pkg::COUNT_W'(to_day - from_day);
            end
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_pair(int sy, int sm, int sd, int ey, int em, int ed,
                            int gap_pct = 0, bit drain = 1'b0);
        t_date_pair p;
        p.req.start_year  = gdd_pkg::YEAR_W'(sy);
        p.req.start_month = gdd_pkg::MONTH_W'(sm);
        p.req.start_day   = gdd_pkg::DAY_W'(sd);
        p.req.end_year    = gdd_pkg::YEAR_W'(ey);
        p.req.end_month   = gdd_pkg::MONTH_W'(em);
        p.req.end_day     = gdd_pkg::DAY_W'(ed);
        p.gap_pct         = gap_pct;
        p.drain           = drain;
        pending_pairs.push_back(p);
    endtask

    // Pick a valid date, leaning toward century years and month ends
    task automatic pick_valid_date(output int y, output int m, output int d);
        int len;
        case ($urandom_range(9))
            0:       y = 1900;
            1:       y = 2100;
            2:       y = 2000;
            default: y = $urandom_range(2100, 1900);
        endcase
        m   = $urandom_range(12, 1);
        len = days_in_month(y, m);
        d   = ($urandom_range(3) == 0) ? len : $urandom_range(len, 1);
    endtask

    task automatic pick_raw_date(output int y, output int m, output int d);
        y = $urandom_range(4095);
        m = $urandom_range(15);
        d = $urandom_range(31);
    endtask

    task automatic add_random_pair(int gap_pct, bit drain);
        int sy, sm, sd, ey, em, ed, t;
        int kind;
        kind = $urandom_range(99);
        pick_valid_date(sy, sm, sd);
        pick_valid_date(ey, em, ed);
        if (kind < 80) begin
            // order forward mostly, backward for a tenth of requests
            if ((day_serial(sy, sm, sd) > day_serial(ey, em, ed)) == (kind < 70)) begin
                t = sy; sy = ey; ey = t;
                t = sm; sm = em; em = t;
                t = sd; sd = ed; ed = t;
            end
        end else if (kind < 85) begin
            ey = sy; em = sm; ed = sd;
        end else if (kind < 90) begin
            pick_raw_date(sy, sm, sd);
        end else if (kind < 95) begin
            pick_raw_date(ey, em, ed);
        end else begin
            pick_raw_date(sy, sm, sd);
            pick_raw_date(ey, em, ed);
        end
        add_pair(sy, sm, sd, ey, em, ed, gap_pct, drain);
    endtask

    task automatic flag_error(string msg);
        if (error_count < MAX_REPORTS) $display("ERROR: %s", msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: present requests at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        drive_start = 1'b0;
        if (!i_rst_n) begin
            drive_start = 1'b0;
        end else if (start && !req_taken) begin
            // hold the request until it is taken
            drive_start = 1'b1;
        end else if (pending_pairs.size() != 0) begin
            if (pending_pairs[0].drain && expected_diffs.size() != 0) begin
                drive_start = 1'b0;
            end else if ($urandom_range(99) < pending_pairs[0].gap_pct) begin
                drive_start = 1'b0;
            end else begin
                next_pair   = pending_pairs.pop_front();
                i_req       <= next_pair.req;
                drive_start = 1'b1;
            end
        end
        start <= drive_start;
    end

    // ------------------------------------------------------------------
    // Monitor: check results and record accepted requests
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_diffs.size() == 0) begin
                    flag_error($sformatf("result with nothing expected: count %0d status %0d",
                                         o_rsp.day_count, o_rsp.status));
                end else begin
                    oldest_diff = expected_diffs.pop_front();
                    if (o_rsp.day_count !== oldest_diff.rsp.day_count ||
                        o_rsp.status !== oldest_diff.rsp.status) begin
                        flag_error($sformatf(
                            "%0d-%0d-%0d to %0d-%0d-%0d: exp %0d/%0d got %0d/%0d",
                            oldest_diff.req.start_year, oldest_diff.req.start_month,
                            oldest_diff.req.start_day, oldest_diff.req.end_year,
                            oldest_diff.req.end_month, oldest_diff.req.end_day,
                            oldest_diff.rsp.day_count, oldest_diff.rsp.status,
                            o_rsp.day_count, o_rsp.status));
                    end
                end
            end
            if (start && !busy) begin
                expected_diffs.push_back(t_expected_diff'{req: i_req,
                                                          rsp: predict_difference(i_req)});
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed requests, random phases, drain
    // ------------------------------------------------------------------
    initial begin
        // full span and its reverse
        add_pair(1900, 1, 1, 2100, 12, 31);
        add_pair(2100, 12, 31, 1900, 1, 1);
        // equal dates, leap day and century rules
        add_pair(2000, 2, 29, 2000, 2, 29);
        add_pair(1900, 1, 1, 1900, 1, 1);
        add_pair(1900, 2, 28, 1900, 3, 1);
        add_pair(2000, 2, 28, 2000, 3, 1);
        add_pair(1999, 12, 31, 2000, 1, 1);
        add_pair(1900, 2, 29, 1901, 1, 1);
        add_pair(1950, 1, 1, 2100, 2, 29);
        add_pair(2004, 2, 29, 2001, 2, 29);
        add_pair(2023, 2, 29, 2024, 2, 29);
        // years out of range
        add_pair(1899, 12, 31, 1900, 1, 1);
        add_pair(2100, 1, 1, 2101, 1, 1);
        add_pair(0, 0, 0, 4095, 15, 31);
        add_pair(4095, 15, 31, 2000, 6, 15);
        // months and days out of range, and valid month ends
        add_pair(1950, 0, 10, 1960, 1, 1);
        add_pair(1950, 13, 10, 1960, 1, 1);
        add_pair(1950, 1, 10, 1960, 15, 1);
        add_pair(1950, 6, 0, 1960, 1, 1);
        add_pair(1950, 4, 31, 1960, 1, 1);
        add_pair(1950, 1, 31, 1950, 12, 31);
        // one day backward at the top of the range
        add_pair(2100, 12, 31, 2100, 12, 30);

        // random phases: no idling, heavy idling, none again, light idling
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                add_random_pair((ph == 1) ? 80 : (ph == 3) ? 27 : 0,
                                (k == 0) || (k == 100));
            end
        end

        // hold reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all requests to be taken and all results to arrive
        while (pending_pairs.size() != 0 || start || expected_diffs.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (error_count == 0 && expected_diffs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
